// ===== sv/mcfc_pkg.sv =====
// shared types, constants and the crc byte fold for the modbus crc frame checker
// no dependencies; compile first
`default_nettype none

package mcfc_pkg;

    localparam int unsigned DELAY_DEPTH = 3;
    localparam int unsigned COUNT_W     = 3;

    localparam logic [15:0]        CRC_INIT      = 16'hFFFF;
    localparam logic [15:0]        CRC_POLY      = 16'hA001;
    localparam logic [COUNT_W-1:0] DELAY_FILL    = COUNT_W'(DELAY_DEPTH);
    localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = 3'd6;
    // frame length is count + 1, so short means count below MIN_FRAME_LEN - 1
    localparam logic [COUNT_W-1:0] SHORT_LIMIT   = MIN_FRAME_LEN - 3'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } byte_item_t;

    typedef struct packed {
        logic        frame_ok;
        logic        too_short;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } check_result_t;

    // reflected crc-16, one byte, lsb first
    function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc_in,
                                                  input logic [7:0]  b);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mcfc_byte_if.sv =====
// valid/ready channel carrying one received frame byte per transaction
// depends on nothing
`default_nettype none

interface mcfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_frame;

    modport source (output valid, output data_byte, output end_of_frame, input ready);
    modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

`default_nettype wire

// ===== sv/mcfc_result_if.sv =====
// valid/ready channel carrying one frame check result per transaction
// depends on nothing
`default_nettype none

interface mcfc_result_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic        too_short;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;

    modport source (output valid, output frame_ok, output too_short,
                    output computed_crc, output received_crc, input ready);
    modport sink   (input valid, input frame_ok, input too_short,
                    input computed_crc, input received_crc, output ready);
endinterface

`default_nettype wire

// ===== sv/mcfc_check_core.sv =====
// frame state (crc accumulator, three-byte delay line, byte count) and result logic
// depends on mcfc_pkg
`default_nettype none

module mcfc_check_core
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire mcfc_pkg::byte_item_t   item,
    output mcfc_pkg::check_result_t     res
);
    import mcfc_pkg::*;

    logic [15:0]        crc_reg;
    logic [15:0]        crc_next;
    logic [7:0]         delay_reg  [DELAY_DEPTH];
    logic [7:0]         delay_next [DELAY_DEPTH];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic [15:0] crc_fed;
    logic [15:0] rx_crc;
    logic        short_frame;

    // oldest byte leaves the full delay line and enters the crc
    assign crc_fed     = (count_reg >= DELAY_FILL) ? crc_fold_byte(crc_reg, delay_reg[0])
                                                   : crc_reg;
    assign rx_crc      = {delay_reg[1], delay_reg[2]};
    assign short_frame = (count_reg < SHORT_LIMIT);

    always_comb
    begin
        res.frame_ok     = !short_frame && (rx_crc == crc_fed);
        res.too_short    = short_frame;
        res.computed_crc = crc_fed;
        res.received_crc = rx_crc;
    end

    always_comb
    begin
        crc_next   = crc_reg;
        delay_next = delay_reg;
        count_next = count_reg;
        if (step)
        begin
            if (item.end_of_frame)
            begin
                crc_next   = CRC_INIT;
                count_next = '0;
                for (int i = 0; i < DELAY_DEPTH; i++)
                begin
                    delay_next[i] = '0;
                end
            end
            else
            begin
                crc_next = crc_fed;
                for (int i = 0; i < DELAY_DEPTH - 1; i++)
                begin
                    delay_next[i] = delay_reg[i + 1];
                end
                delay_next[DELAY_DEPTH - 1] = item.data_byte;
                if (count_reg < MIN_FRAME_LEN)
                    count_next = count_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
            for (int i = 0; i < DELAY_DEPTH; i++)
            begin
                delay_reg[i] <= '0;
            end
        end
        else
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            delay_reg <= delay_next;
        end
    end

`ifndef ASSERT_OFF
    a_terminator_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.end_of_frame |=> crc_reg == CRC_INIT && count_reg == '0
                                      && delay_reg[1] == '0 && delay_reg[2] == '0)
        else $error("frame state not restarted after terminator");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MIN_FRAME_LEN)
        else $error("byte count beyond saturation");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(crc_reg) && $stable(count_reg))
        else $error("frame state changed without a byte");
`endif

endmodule

`default_nettype wire

// ===== sv/modbus_crc_frame_checker_top.sv =====
// Modbus-style CRC-16 frame checker: takes one frame byte per cycle, with no
// bubbles between bytes or frames unless a terminator stalls (below). A byte is
// captured in an input register; as it advances into the frame state, the oldest
// byte of a full delay line takes an 8-bit reflected CRC fold (polynomial 0xA001,
// init 0xFFFF) as unrolled XOR logic, and a terminator byte loads the result
// register. The last two bytes before the terminator are the received CRC, high
// byte first; frames under six bytes including the terminator are flagged too
// short. The result register is a single slot: while it waits, payload bytes
// keep flowing and only a second terminator stalls.
// depends on mcfc_pkg, mcfc_byte_if, mcfc_result_if, mcfc_check_core
`default_nettype none

module modbus_crc_frame_checker_top
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    mcfc_byte_if.sink         frame,
    mcfc_result_if.source     result
);
    import mcfc_pkg::*;

    logic          stage_valid_reg;
    logic          stage_valid_next;
    byte_item_t    stage_item_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    check_result_t out_res_reg;

    logic          out_free;
    logic          stage_advance;
    logic          load_result;
    check_result_t core_res;

    assign out_free      = !out_valid_reg || result.ready;
    assign stage_advance = stage_valid_reg && (!stage_item_reg.end_of_frame || out_free);
    assign load_result   = stage_advance && stage_item_reg.end_of_frame;
    assign frame.ready   = !stage_valid_reg || stage_advance;

    mcfc_check_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (stage_advance),
        .item  (stage_item_reg),
        .res   (core_res)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (frame.ready)
            stage_valid_next = frame.valid;

        out_valid_next = out_valid_reg;
        if (load_result)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            stage_item_reg.data_byte    <= frame.data_byte;
            stage_item_reg.end_of_frame <= frame.end_of_frame;
        end
        if (load_result)
            out_res_reg <= core_res;
    end

    assign result.valid        = out_valid_reg;
    assign result.frame_ok     = out_res_reg.frame_ok;
    assign result.too_short    = out_res_reg.too_short;
    assign result.computed_crc = out_res_reg.computed_crc;
    assign result.received_crc = out_res_reg.received_crc;

`ifndef ASSERT_OFF
    a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !stage_advance |=> stage_valid_reg && $stable(stage_item_reg))
        else $error("held byte lost from input register");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> out_valid_reg && out_res_reg == $past(core_res))
        else $error("terminator did not produce a result");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_res_reg.frame_ok && out_res_reg.too_short))
        else $error("short frame reported as ok");
`endif

endmodule

`default_nettype wire

// ===== verif/modbus_crc_frame_checker_top_test.sv =====
`timescale 1ns / 100ps
// testbench for modbus_crc_frame_checker_top: directed and random frames,
// with results predicted per byte and compared field by field
// depends on mcfc_pkg, mcfc_byte_if, mcfc_result_if and the block itself

module modbus_crc_frame_checker_top_test;
    import mcfc_pkg::*;

    typedef logic [7:0] octet_q_t [$];

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_GAP        = 12;

    logic clk;
    logic rst_n;

    mcfc_byte_if   frame_ch ();
    mcfc_result_if result_ch ();

    modbus_crc_frame_checker_top u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch)
    );

    check_result_t expected_results [$];
    int            error_count;
    int            items_sent;
    int            idle_cycles;
    int            src_idle_pct;
    int            snk_stall_pct;

    // predicted frame state
    logic [15:0]        pred_crc;
    logic [7:0]         pred_line [DELAY_DEPTH];
    logic [COUNT_W-1:0] pred_count;

    // bit-serial form of the reflected crc-16 update
    function automatic logic [15:0] modbus_crc_update(input logic [15:0] crc_in,
                                                      input logic [7:0]  d);
        logic [15:0] r;
        logic        fb;
        r = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ d[i];
            r  = {1'b0, r[15:1]};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic logic [15:0] modbus_crc_of(input octet_q_t bytes);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (bytes[i])
            c = modbus_crc_update(c, bytes[i]);
        return c;
    endfunction

    task automatic clear_frame_state();
        pred_crc = CRC_INIT;
        foreach (pred_line[i])
            pred_line[i] = 8'h00;
        pred_count = '0;
    endtask

    task automatic predict_octet(input logic [7:0] b, input logic eof);
        check_result_t res;
        logic [15:0]   rx;
        logic          short_frame;
        // oldest byte leaves the full delay line into the crc
        if (pred_count >= DELAY_FILL)
            pred_crc = modbus_crc_update(pred_crc, pred_line[0]);
        if (!eof)
        begin
            pred_line[0] = pred_line[1];
            pred_line[1] = pred_line[2];
            pred_line[2] = b;
            if (pred_count < MIN_FRAME_LEN)
                pred_count = pred_count + 1'b1;
        end
        else
        begin
            rx               = {pred_line[1], pred_line[2]};
            short_frame      = (int'(pred_count) + 1) < int'(MIN_FRAME_LEN);
            res.frame_ok     = !short_frame && (rx == pred_crc);
            res.too_short    = short_frame;
            res.computed_crc = pred_crc;
            res.received_crc = rx;
            expected_results.push_back(res);
            clear_frame_state();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);

    // result check, then prediction, at every rising edge
    always @(posedge clk)
    begin
        check_result_t got;
        check_result_t want;
        logic          busy;
        busy = 1'b0;
        if (result_ch.valid && result_ch.ready)
        begin
            busy             = 1'b1;
            got.frame_ok     = result_ch.frame_ok;
            got.too_short    = result_ch.too_short;
            got.computed_crc = result_ch.computed_crc;
            got.received_crc = result_ch.received_crc;
            if (expected_results.size() == 0)
                report_mismatch("result with no frame pending", got.computed_crc, 16'h0);
            else
            begin
                want = expected_results.pop_front();
                if (got.frame_ok !== want.frame_ok)
                    report_mismatch("frame_ok", 16'(got.frame_ok), 16'(want.frame_ok));
                if (got.too_short !== want.too_short)
                    report_mismatch("too_short", 16'(got.too_short), 16'(want.too_short));
                if (got.computed_crc !== want.computed_crc)
                    report_mismatch("computed_crc", got.computed_crc, want.computed_crc);
                if (got.received_crc !== want.received_crc)
                    report_mismatch("received_crc", got.received_crc, want.received_crc);
            end
        end
        if (frame_ch.valid && frame_ch.ready)
        begin
            busy = 1'b1;
            predict_octet(frame_ch.data_byte, frame_ch.end_of_frame);
        end
        idle_cycles = busy ? 0 : idle_cycles + 1;
    end

    initial
    begin
        do
            @(posedge clk);
        while (idle_cycles < WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_octet(input logic [7:0] b, input logic eof);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_ch.valid        <= 1'b1;
        frame_ch.data_byte    <= b;
        frame_ch.end_of_frame <= eof;
        do
            @(posedge clk);
        while (!frame_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input octet_q_t body, input logic [7:0] term);
        foreach (body[i])
            send_octet(body[i], 1'b0);
        send_octet(term, 1'b1);
    endtask

    task automatic pause_until_drained();
        frame_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic send_random_frame();
        octet_q_t    body;
        logic [15:0] crc;
        int          kind;
        int          len;
        int          pos;
        kind = $urandom_range(0, 99);
        if (kind < 85)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            repeat (len)
                body.push_back(8'($urandom));
            crc = modbus_crc_of(body);
            body.push_back(crc[15:8]);
            body.push_back(crc[7:0]);
            if (kind >= 70)
            begin
                // single bit error in payload or crc
                pos       = $urandom_range(0, body.size() - 1);
                body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        else
        begin
            len = (kind < 95) ? $urandom_range(0, 12) : $urandom_range(0, 4);
            repeat (len)
                body.push_back(8'($urandom));
        end
        send_frame(body, 8'($urandom));
    endtask

    task automatic run_random_frames(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
            send_random_frame();
    endtask

    task automatic test_directed_frames();
        octet_q_t    body;
        logic [15:0] crc;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        // lone terminator
        body.delete();
        send_frame(body, 8'hFF);
        // one byte only, high half of received crc never filled
        body = '{8'hA5};
        send_frame(body, 8'h00);
        // one byte under the minimum length
        body = '{8'h00, 8'hFF, 8'h12, 8'h34};
        send_frame(body, 8'hFF);
        // empty payload: crc bytes match but the frame is short
        body = '{8'hFF, 8'hFF};
        send_frame(body, 8'h00);
        // minimum length, good crc
        body = '{8'h00, 8'hFF, 8'h5A};
        crc  = modbus_crc_of(body);
        body.push_back(crc[15:8]);
        body.push_back(crc[7:0]);
        send_frame(body, 8'h00);
        // minimum length, crc off in the low bit
        body = '{8'hFF, 8'hFF, 8'hFF};
        crc  = modbus_crc_of(body) ^ 16'h0001;
        body.push_back(crc[15:8]);
        body.push_back(crc[7:0]);
        send_frame(body, 8'hFF);
    endtask

    task automatic test_back_to_back();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        run_random_frames(280);
    endtask

    task automatic test_sender_gaps();
        src_idle_pct  = 51;
        snk_stall_pct = 0;
        run_random_frames(140);
        pause_until_drained();
        run_random_frames(140);
    endtask

    task automatic test_receiver_stalls();
        src_idle_pct  = 0;
        snk_stall_pct = 51;
        run_random_frames(280);
    endtask

    task automatic test_mixed_idling();
        src_idle_pct  = 22;
        snk_stall_pct = 22;
        run_random_frames(260);
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        frame_ch.valid        = 1'b0;
        frame_ch.data_byte    = 8'h00;
        frame_ch.end_of_frame = 1'b0;
        error_count           = 0;
        items_sent            = 0;
        idle_cycles           = 0;
        src_idle_pct          = 0;
        snk_stall_pct         = 0;
        clear_frame_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_frames();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();

        frame_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
